[hdl/mfm_pkg.sv]
// Package for the machine fault monitor: field widths, register indexes,
// error codes and reset values. No dependencies.
`default_nettype none

package mfm_pkg;

    // payload field widths
    localparam int unsigned POS_W   = 3;
    localparam int unsigned GUARD_W = 2;
    localparam int unsigned MOT_W   = 3;
    localparam int unsigned STEP_W  = 24;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned STOP_W  = 4;
    localparam int unsigned LPOS_W  = 2;

    // packed widths on the stream ports
    localparam int unsigned IN_BITS   = 89;
    localparam int unsigned IN_TDATA  = 96;
    localparam int unsigned OUT_BITS  = 9;
    localparam int unsigned OUT_TDATA = 16;

    // configuration port
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_M2_LIMIT = 3'd0;
    localparam t_reg_idx REG_M3_LIMIT = 3'd1;
    localparam t_reg_idx REG_M4_LIMIT = 3'd2;
    localparam t_reg_idx REG_FILM_TO  = 3'd3;
    localparam t_reg_idx REG_BLANKING = 3'd4;

    typedef logic [CODE_W-1:0] t_code;
    localparam t_code ERR_NONE     = 4'd0;
    localparam t_code ERR_GUARD    = 4'd1;
    localparam t_code ERR_M2_OVER  = 4'd2;
    localparam t_code ERR_FILM     = 4'd5;
    localparam t_code ERR_INIT     = 4'd6;
    localparam t_code ERR_MULTI    = 4'd7;
    localparam t_code ERR_SEQ_3_2  = 4'd8;
    localparam t_code ERR_SEQ_1_3  = 4'd9;
    localparam t_code ERR_SEQ_2_1  = 4'd10;

    // last seen position sensor
    typedef logic [LPOS_W-1:0] t_lpos;
    localparam t_lpos LPOS_NONE = 2'd0;
    localparam t_lpos LPOS_ONE  = 2'd1;
    localparam t_lpos LPOS_TWO  = 2'd2;
    localparam t_lpos LPOS_THREE = 2'd3;

    localparam logic [STEP_W-1:0]  RST_STEP_LIMIT = 24'd65535;
    localparam logic [TIMER_W-1:0] RST_FILM_TO    = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_BLANKING   = 16'd100;

endpackage

`default_nettype wire

[hdl/machine_fault_monitor.sv]
// Machine fault monitor top level: input register, per-tick fault checks,
// output register, APB register file. Depends on mfm_pkg.
`default_nettype none

// Usage
//   One request on s_axis is one millisecond tick snapshot of sensors, magnets
//   and motor step counts. For each request exactly one result request leaves
//   on m_axis: fault flag, error code (last check that fired wins) and motor
//   stop bits. Registers (step limits, film timeout, blanking length) sit on
//   the APB port; the user must write them only while the block is idle, the
//   block does not enforce it. Writing the film timeout reloads the film
//   timer, writing the blanking length restarts blanking.
//   Path: input register, then the checks, then the result register.
//   Throughput: one request per cycle while m_axis_tready holds, set by
//   the single pass of check logic between the two registers; per-tick
//   state (film timer, blanking count, last position) updates in the same
//   cycle the result is registered.
//   Reset (synchronous, active low) restores register defaults (limits 65535,
//   film timeout 1000, blanking 100), clears last position and empties both
//   stages. While blanking counts down, results are all zero.
//   When the receiver stalls the result holds in the output register; the
//   input register still takes one more request, then s_axis_tready drops.
module machine_fault_monitor #(
    parameter int unsigned STEP_COUNT_BITS = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // stream in, tdata from bit 0: position_sensors[3], guard_sensors[2],
    // film_sensor, init_present, machine_in_init, motor_enables[3],
    // home_sensors[3], motor2_steps[24], motor3_steps[24], motor4_steps[24],
    // magnet_states[3], zero fill
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [mfm_pkg::IN_TDATA-1:0]        s_axis_tdata,
    // stream out, tdata from bit 0: fault, error_code[4], stop_motors[4],
    // zero fill
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [mfm_pkg::OUT_TDATA-1:0]            m_axis_tdata,
    // APB register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mfm_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [mfm_pkg::DATA_W-1:0]          pwdata,
    output logic [mfm_pkg::DATA_W-1:0]               prdata,
    output logic                                     pready
);

    // compare width: step counts are 24 bits, compared in their low
    // STEP_COUNT_BITS bits (all 24 bits when STEP_COUNT_BITS is larger)
    localparam int unsigned CMP_W =
        (STEP_COUNT_BITS < mfm_pkg::STEP_W) ? STEP_COUNT_BITS : mfm_pkg::STEP_W;

    // ---------------- registers ----------------
    logic [mfm_pkg::STEP_W-1:0]   r_m2_limit, r_m3_limit, r_m4_limit;
    logic [mfm_pkg::TIMER_W-1:0]  r_film_to, r_blanking;

    logic [mfm_pkg::TIMER_W-1:0]  r_film_timer, n_film_timer;
    logic [mfm_pkg::TIMER_W-1:0]  r_blank_cnt, n_blank_cnt;
    mfm_pkg::t_lpos               r_last_pos, n_last_pos;

    logic                         r_in_valid;
    logic [mfm_pkg::IN_BITS-1:0]  r_in_data;
    logic                         r_out_valid;
    logic [mfm_pkg::OUT_BITS-1:0] r_out_data, n_out_data;

    logic                         w_cfg_wr;
    mfm_pkg::t_reg_idx            w_idx;
    logic                         w_adv;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign w_idx    = paddr[mfm_pkg::ADDR_W-1:2];

    // stage handshake: input stage moves into output register when that is
    // free or being drained this cycle
    assign w_adv         = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(mfm_pkg::OUT_TDATA - mfm_pkg::OUT_BITS){1'b0}}, r_out_data};

    // register readback
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            mfm_pkg::REG_M2_LIMIT: prdata = {8'd0, r_m2_limit};
            mfm_pkg::REG_M3_LIMIT: prdata = {8'd0, r_m3_limit};
            mfm_pkg::REG_M4_LIMIT: prdata = {8'd0, r_m4_limit};
            mfm_pkg::REG_FILM_TO:  prdata = {16'd0, r_film_to};
            mfm_pkg::REG_BLANKING: prdata = {16'd0, r_blanking};
            default:               prdata = '0;
        endcase
    end

    // ---------------- input field unpack ----------------
    logic [2:0]                  w_pos;
    logic [1:0]                  w_guard;
    logic                        w_film, w_init_ok, w_in_init;
    logic [2:0]                  w_en, w_home, w_mag;
    logic [mfm_pkg::STEP_W-1:0]  w_steps [3];
    logic [mfm_pkg::STEP_W-1:0]  w_limit [3];

    assign w_pos      = r_in_data[2:0];
    assign w_guard    = r_in_data[4:3];
    assign w_film     = r_in_data[5];
    assign w_init_ok  = r_in_data[6];
    assign w_in_init  = r_in_data[7];
    assign w_en       = r_in_data[10:8];
    assign w_home     = r_in_data[13:11];
    assign w_steps[0] = r_in_data[37:14];
    assign w_steps[1] = r_in_data[61:38];
    assign w_steps[2] = r_in_data[85:62];
    assign w_mag      = r_in_data[88:86];
    assign w_limit[0] = r_m2_limit;
    assign w_limit[1] = r_m3_limit;
    assign w_limit[2] = r_m4_limit;

    // ---------------- checks ----------------
    logic                        w_film_run;
    logic [mfm_pkg::TIMER_W-1:0] w_timer_dec;
    logic                        w_any;
    mfm_pkg::t_code              w_code;
    logic [mfm_pkg::STOP_W-1:0]  w_stops;

    assign w_film_run  = (w_mag[2] & w_film) | (w_mag[0] & w_mag[1] & ~w_film);
    assign w_timer_dec = (r_film_timer != '0) ?
                         r_film_timer - mfm_pkg::TIMER_W'(1) : '0;

    always_comb begin
        n_blank_cnt  = r_blank_cnt;
        n_film_timer = r_film_timer;
        n_last_pos   = r_last_pos;
        w_any        = 1'b0;
        w_code       = mfm_pkg::ERR_NONE;
        w_stops      = '0;

        if (r_blank_cnt != '0) begin
            n_blank_cnt = r_blank_cnt - mfm_pkg::TIMER_W'(1);
        end else begin
            if (w_guard != 2'b11) begin
                w_stops[0] = 1'b1;
                w_code     = mfm_pkg::ERR_GUARD;
                w_any      = 1'b1;
            end
            for (int k = 0; k < 3; k++) begin
                if (w_en[k] && w_home[k] &&
                    (w_steps[k][CMP_W-1:0] > w_limit[k][CMP_W-1:0])) begin
                    w_stops[k+1] = 1'b1;
                    w_code       = mfm_pkg::ERR_M2_OVER + mfm_pkg::CODE_W'(k);
                    w_any        = 1'b1;
                end
            end
            // film timer counts down and sticks at zero
            if (w_film_run) begin
                n_film_timer = w_timer_dec;
                if (w_timer_dec == '0) begin
                    w_code = mfm_pkg::ERR_FILM;
                    w_any  = 1'b1;
                end
            end else begin
                n_film_timer = r_film_to;
            end
            if (w_in_init && !w_any && !w_init_ok) begin
                w_code = mfm_pkg::ERR_INIT;
                w_any  = 1'b1;
            end
            if ((w_pos[0] && (w_pos[1] || w_pos[2])) || (w_pos[1] && w_pos[2])) begin
                w_code = mfm_pkg::ERR_MULTI;
                w_any  = 1'b1;
            end
            // sequence: sensor two, then one, then three
            if (w_pos[1]) begin
                if (n_last_pos == mfm_pkg::LPOS_ONE) begin
                    w_code = mfm_pkg::ERR_SEQ_2_1;
                    w_any  = 1'b1;
                end
                n_last_pos = mfm_pkg::LPOS_TWO;
            end
            if (w_pos[0]) begin
                if (n_last_pos == mfm_pkg::LPOS_THREE) begin
                    w_code = mfm_pkg::ERR_SEQ_1_3;
                    w_any  = 1'b1;
                end
                n_last_pos = mfm_pkg::LPOS_ONE;
            end
            if (w_pos[2]) begin
                if (n_last_pos == mfm_pkg::LPOS_TWO) begin
                    w_code = mfm_pkg::ERR_SEQ_3_2;
                    w_any  = 1'b1;
                end
                n_last_pos = mfm_pkg::LPOS_THREE;
            end
        end
        n_out_data = {w_stops, w_code, w_any};
    end

    // ---------------- sequential ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_limit   <= mfm_pkg::RST_STEP_LIMIT;
            r_m3_limit   <= mfm_pkg::RST_STEP_LIMIT;
            r_m4_limit   <= mfm_pkg::RST_STEP_LIMIT;
            r_film_to    <= mfm_pkg::RST_FILM_TO;
            r_blanking   <= mfm_pkg::RST_BLANKING;
            r_film_timer <= mfm_pkg::RST_FILM_TO;
            r_blank_cnt  <= mfm_pkg::RST_BLANKING;
            r_last_pos   <= mfm_pkg::LPOS_NONE;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // per-tick state moves with the request into the output register
            if (w_adv) begin
                r_film_timer <= n_film_timer;
                r_blank_cnt  <= n_blank_cnt;
                r_last_pos   <= n_last_pos;
            end
            // register writes must come only while idle; the block does not enforce it
            if (w_cfg_wr) begin
                unique case (w_idx)
                    mfm_pkg::REG_M2_LIMIT: r_m2_limit <= pwdata[mfm_pkg::STEP_W-1:0];
                    mfm_pkg::REG_M3_LIMIT: r_m3_limit <= pwdata[mfm_pkg::STEP_W-1:0];
                    mfm_pkg::REG_M4_LIMIT: r_m4_limit <= pwdata[mfm_pkg::STEP_W-1:0];
                    mfm_pkg::REG_FILM_TO: begin
                        r_film_to    <= pwdata[mfm_pkg::TIMER_W-1:0];
                        r_film_timer <= pwdata[mfm_pkg::TIMER_W-1:0];
                    end
                    mfm_pkg::REG_BLANKING: begin
                        r_blanking  <= pwdata[mfm_pkg::TIMER_W-1:0];
                        r_blank_cnt <= pwdata[mfm_pkg::TIMER_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[mfm_pkg::IN_BITS-1:0];
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // ---------------- assertions ----------------
    a_no_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[mfm_pkg::OUT_BITS-1:1] == '0))
        else $error("result without fault carries a code or stop bits");

    a_stop_has_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[8:5] != '0)) |-> r_out_data[0])
        else $error("stop bits raised without fault");

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_blank_cnt != '0)) |=> (r_out_data == '0))
        else $error("nonzero result during blanking");

    a_timer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_film_timer <= r_film_to)
        else $error("film timer above its reload value");

    a_lpos_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_pos != mfm_pkg::LPOS_NONE) |=> (r_last_pos != mfm_pkg::LPOS_NONE))
        else $error("last position cleared outside reset");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for machine_fault_monitor: directed plan plus random
// ticks, results checked against an in-bench fault predictor or a fixed expected verdict.
// Depends on mfm_pkg and the machine_fault_monitor RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_TICKS    = 190;
    localparam int TAIL_CYCLES    = 10;

    // index with no register behind it; writes there must be dropped
    localparam mfm_pkg::t_reg_idx REG_UNMAPPED = 3'd5;

    // step count shorthands for the plan
    localparam logic [mfm_pkg::STEP_W-1:0] S0   = '0;
    localparam logic [mfm_pkg::STEP_W-1:0] SMAX = '1;

    // one tick snapshot, declared MSB first so it packs straight onto tdata
    typedef struct packed {
        logic [mfm_pkg::MOT_W-1:0]          mag;
        logic [2:0][mfm_pkg::STEP_W-1:0]    steps;   // [0] motor two .. [2] motor four
        logic [mfm_pkg::MOT_W-1:0]          home;
        logic [mfm_pkg::MOT_W-1:0]          en;
        logic                               in_init;
        logic                               init_ok;
        logic                               film;
        logic [mfm_pkg::GUARD_W-1:0]        guard;
        logic [mfm_pkg::POS_W-1:0]          pos;
    } t_tick;

    typedef struct packed {
        logic [mfm_pkg::STOP_W-1:0] stops;
        mfm_pkg::t_code             code;
        logic                       fault;
    } t_verdict;

    typedef enum logic {ACT_TICK, ACT_CFG} t_act;

    typedef struct {
        t_act                       act;
        mfm_pkg::t_reg_idx          idx;
        logic [mfm_pkg::DATA_W-1:0] value;
        t_tick                      tick;
        bit                         fixed_want;
        t_verdict                   want;
    } t_plan_row;

    // ------------------------------------------------------------------
    // DUT signals; inputs all at known values from time zero
    // ------------------------------------------------------------------
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [mfm_pkg::IN_TDATA-1:0]  s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [mfm_pkg::OUT_TDATA-1:0] m_axis_tdata;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [mfm_pkg::ADDR_W-1:0]    paddr         = '0;
    logic [mfm_pkg::DATA_W-1:0]    pwdata        = '0;
    logic [mfm_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    machine_fault_monitor #(
        .STEP_COUNT_BITS(mfm_pkg::STEP_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pos, guard, film, init, in_init, en, home,
                                         // m2..m4 steps, magnets, zero fill
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // fault, error_code, stop_motors, zero fill
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: register copies and per-tick state
    // ------------------------------------------------------------------
    logic [2:0][mfm_pkg::STEP_W-1:0] step_limit;
    logic [mfm_pkg::TIMER_W-1:0]     film_reload;
    logic [mfm_pkg::TIMER_W-1:0]     blank_len;
    logic [mfm_pkg::TIMER_W-1:0]     film_left;
    logic [mfm_pkg::TIMER_W-1:0]     blank_left;
    mfm_pkg::t_lpos                  last_pos;

    t_verdict  pending_verdicts[$];
    t_plan_row plan[$];

    int fail_count    = 0;
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int quiet_cycles  = 0;

    // Fault checks of one tick, in the block's order; last one to fire owns the code.
    function automatic t_verdict judge_tick(input t_tick t);
        t_verdict v;
        logic     film_run;
        int       k;
        v = '0;
        // blanking: count down, report nothing, touch no other state
        if (blank_left != '0) begin
            blank_left = blank_left - mfm_pkg::TIMER_W'(1);
            return v;
        end
        if (t.guard != 2'b11) begin
            v.stops[0] = 1'b1;
            v.code     = mfm_pkg::ERR_GUARD;
            v.fault    = 1'b1;
        end
        for (k = 0; k < 3; k++) begin
            if (t.en[k] && t.home[k] && (t.steps[k] > step_limit[k])) begin
                v.stops[k+1] = 1'b1;
                v.code       = mfm_pkg::t_code'(mfm_pkg::ERR_M2_OVER + k);
                v.fault      = 1'b1;
            end
        end
        // film timer runs on a sensor/magnet disagreement and sticks at zero
        film_run = (t.mag[2] && t.film) || (t.mag[0] && t.mag[1] && !t.film);
        if (film_run) begin
            if (film_left != '0)
                film_left = film_left - mfm_pkg::TIMER_W'(1);
            if (film_left == '0) begin
                v.code  = mfm_pkg::ERR_FILM;
                v.fault = 1'b1;
            end
        end else begin
            film_left = film_reload;
        end
        // init sensor only counts when nothing else fired yet
        if (t.in_init && !v.fault && !t.init_ok) begin
            v.code  = mfm_pkg::ERR_INIT;
            v.fault = 1'b1;
        end
        if ((t.pos[0] && (t.pos[1] || t.pos[2])) || (t.pos[1] && t.pos[2])) begin
            v.code  = mfm_pkg::ERR_MULTI;
            v.fault = 1'b1;
        end
        // sequence: sensor two, then one, then three, each updating last_pos
        if (t.pos[1]) begin
            if (last_pos == mfm_pkg::LPOS_ONE) begin
                v.code  = mfm_pkg::ERR_SEQ_2_1;
                v.fault = 1'b1;
            end
            last_pos = mfm_pkg::LPOS_TWO;
        end
        if (t.pos[0]) begin
            if (last_pos == mfm_pkg::LPOS_THREE) begin
                v.code  = mfm_pkg::ERR_SEQ_1_3;
                v.fault = 1'b1;
            end
            last_pos = mfm_pkg::LPOS_ONE;
        end
        if (t.pos[2]) begin
            if (last_pos == mfm_pkg::LPOS_TWO) begin
                v.code  = mfm_pkg::ERR_SEQ_3_2;
                v.fault = 1'b1;
            end
            last_pos = mfm_pkg::LPOS_THREE;
        end
        return v;
    endfunction

    function automatic t_tick mk_tick(
        input logic [2:0] pos, input logic [1:0] guard, input logic film,
        input logic init_ok, input logic in_init, input logic [2:0] en,
        input logic [2:0] home, input logic [mfm_pkg::STEP_W-1:0] m2,
        input logic [mfm_pkg::STEP_W-1:0] m3, input logic [mfm_pkg::STEP_W-1:0] m4,
        input logic [2:0] mag);
        t_tick t;
        t.pos     = pos;
        t.guard   = guard;
        t.film    = film;
        t.init_ok = init_ok;
        t.in_init = in_init;
        t.en      = en;
        t.home    = home;
        t.steps   = {m4, m3, m2};
        t.mag     = mag;
        return t;
    endfunction

    function automatic t_verdict mk_verdict(input logic f, input mfm_pkg::t_code c,
                                            input logic [mfm_pkg::STOP_W-1:0] s);
        t_verdict v;
        v.fault = f;
        v.code  = c;
        v.stops = s;
        return v;
    endfunction

    function automatic void add_tick(input t_tick t);
        t_plan_row r;
        r.act        = ACT_TICK;
        r.idx        = mfm_pkg::REG_M2_LIMIT;
        r.value      = '0;
        r.tick       = t;
        r.fixed_want = 1'b0;
        r.want       = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_typed(input t_tick t, input t_verdict v);
        t_plan_row r;
        r.act        = ACT_TICK;
        r.idx        = mfm_pkg::REG_M2_LIMIT;
        r.value      = '0;
        r.tick       = t;
        r.fixed_want = 1'b1;
        r.want       = v;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(input mfm_pkg::t_reg_idx idx,
                                    input logic [mfm_pkg::DATA_W-1:0] val);
        t_plan_row r;
        r.act        = ACT_CFG;
        r.idx        = idx;
        r.value      = val;
        r.tick       = '0;
        r.fixed_want = 1'b0;
        r.want       = '0;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic push_tick(input t_tick t, input bit fixed_want, input t_verdict want);
        t_verdict v;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(mfm_pkg::IN_TDATA-mfm_pkg::IN_BITS){1'b0}}, t};
        do @(posedge i_clk); while (!s_axis_tready);
        v = judge_tick(t);
        pending_verdicts.push_back(fixed_want ? want : v);
        @(negedge i_clk);
    endtask

    // drop the request and hold off until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
    endtask

    // APB write, mirrored into the predictor, then a read-back of mapped registers
    task automatic program_reg(input mfm_pkg::t_reg_idx idx,
                               input logic [mfm_pkg::DATA_W-1:0] val);
        logic [mfm_pkg::DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            mfm_pkg::REG_M2_LIMIT: step_limit[0] = val[mfm_pkg::STEP_W-1:0];
            mfm_pkg::REG_M3_LIMIT: step_limit[1] = val[mfm_pkg::STEP_W-1:0];
            mfm_pkg::REG_M4_LIMIT: step_limit[2] = val[mfm_pkg::STEP_W-1:0];
            mfm_pkg::REG_FILM_TO: begin
                film_reload = val[mfm_pkg::TIMER_W-1:0];
                film_left   = val[mfm_pkg::TIMER_W-1:0];
            end
            mfm_pkg::REG_BLANKING: begin
                blank_len  = val[mfm_pkg::TIMER_W-1:0];
                blank_left = val[mfm_pkg::TIMER_W-1:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx <= mfm_pkg::REG_BLANKING) begin
            case (idx)
                mfm_pkg::REG_M2_LIMIT: want = mfm_pkg::DATA_W'(step_limit[0]);
                mfm_pkg::REG_M3_LIMIT: want = mfm_pkg::DATA_W'(step_limit[1]);
                mfm_pkg::REG_M4_LIMIT: want = mfm_pkg::DATA_W'(step_limit[2]);
                mfm_pkg::REG_FILM_TO:  want = mfm_pkg::DATA_W'(film_reload);
                default:               want = mfm_pkg::DATA_W'(blank_len);
            endcase
            @(negedge i_clk);
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata !== want) begin
                $error("prdata[%0d]: expected %0h, got %0h", idx, want, prdata);
                fail_count++;
            end
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= dst_stall_pct);

    // ------------------------------------------------------------------
    // Result checker: oldest pending verdict against each accepted result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_verdict got;
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[mfm_pkg::OUT_BITS-1:0];
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: fault %0d code %0d stops %0h",
                       got.fault, got.code, got.stops);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.fault !== want.fault) begin
                    $error("fault: expected %0d, got %0d", want.fault, got.fault);
                    fail_count++;
                end
                if (got.code !== want.code) begin
                    $error("error_code: expected %0d, got %0d", want.code, got.code);
                    fail_count++;
                end
                if (got.stops !== want.stops) begin
                    $error("stop_motors: expected %0h, got %0h", want.stops, got.stops);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without any request moving on either stream or APB
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        t_tick                           t;
        logic [2:0][mfm_pkg::POS_W-1:0]  fwd;
        logic [2:0]                      sim_mag;
        logic                            sim_film;
        int                              seq_step;
        int                              r;
        int                              ph;
        int                              n;
        int                              k;
        logic [mfm_pkg::DATA_W-1:0]      val;

        fwd      = {3'b100, 3'b001, 3'b010};   // forward order: two, one, three
        sim_mag  = '0;
        sim_film = 1'b0;
        seq_step = 0;

        // predictor at its reset state
        step_limit  = {mfm_pkg::RST_STEP_LIMIT, mfm_pkg::RST_STEP_LIMIT,
                       mfm_pkg::RST_STEP_LIMIT};
        film_reload = mfm_pkg::RST_FILM_TO;
        film_left   = mfm_pkg::RST_FILM_TO;
        blank_len   = mfm_pkg::RST_BLANKING;
        blank_left  = mfm_pkg::RST_BLANKING;
        last_pos    = mfm_pkg::LPOS_NONE;

        // directed plan
        // still blanking after reset: everything reads zero whatever the inputs
        add_typed(mk_tick(3'b111, 2'b00, 1'b1, 1'b0, 1'b1, 3'b111, 3'b111, SMAX, SMAX,
                          SMAX, 3'b011), mk_verdict(1'b0, mfm_pkg::ERR_NONE, 4'h0));
        add_typed(mk_tick(3'b010, 2'b01, 1'b0, 1'b0, 1'b1, 3'b000, 3'b000, S0, S0, S0,
                          3'b100), mk_verdict(1'b0, mfm_pkg::ERR_NONE, 4'h0));
        add_cfg(mfm_pkg::REG_BLANKING, 32'd0);
        add_typed(mk_tick(3'b000, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                          3'b000), mk_verdict(1'b0, mfm_pkg::ERR_NONE, 4'h0));
        add_typed(mk_tick(3'b000, 2'b00, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                          3'b000), mk_verdict(1'b1, mfm_pkg::ERR_GUARD, 4'h1));
        add_tick(mk_tick(3'b000, 2'b10, 1'b0, 1'b1, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        // overrun by one on motor two; exactly at the limit on motor three
        add_typed(mk_tick(3'b000, 2'b11, 1'b0, 1'b0, 1'b0, 3'b001, 3'b001, 24'd65536, S0,
                          S0, 3'b000), mk_verdict(1'b1, mfm_pkg::ERR_M2_OVER, 4'h2));
        add_typed(mk_tick(3'b000, 2'b11, 1'b0, 1'b0, 1'b0, 3'b010, 3'b010, S0, 24'd65535,
                          S0, 3'b000), mk_verdict(1'b0, mfm_pkg::ERR_NONE, 4'h0));
        add_typed(mk_tick(3'b000, 2'b11, 1'b0, 1'b0, 1'b0, 3'b100, 3'b100, S0, S0, SMAX,
                          3'b000),
                  mk_verdict(1'b1, mfm_pkg::t_code'(mfm_pkg::ERR_M2_OVER + 2), 4'h8));
        // every stop raised at once, motor four owns the code
        add_typed(mk_tick(3'b000, 2'b00, 1'b0, 1'b0, 1'b0, 3'b111, 3'b111, SMAX, SMAX,
                          SMAX, 3'b000),
                  mk_verdict(1'b1, mfm_pkg::t_code'(mfm_pkg::ERR_M2_OVER + 2), 4'hF));
        add_typed(mk_tick(3'b000, 2'b11, 1'b0, 1'b0, 1'b1, 3'b000, 3'b000, S0, S0, S0,
                          3'b000), mk_verdict(1'b1, mfm_pkg::ERR_INIT, 4'h0));
        // init check masked by an earlier guard fault
        add_tick(mk_tick(3'b000, 2'b01, 1'b0, 1'b0, 1'b1, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        // position sequence: multi, forward steps, then each backward step
        add_tick(mk_tick(3'b011, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        add_tick(mk_tick(3'b100, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        add_tick(mk_tick(3'b010, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        add_tick(mk_tick(3'b100, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        add_tick(mk_tick(3'b001, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        add_tick(mk_tick(3'b010, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b000));
        // film timeout of zero faults on the first disagreeing tick
        add_cfg(mfm_pkg::REG_FILM_TO, 32'd0);
        add_typed(mk_tick(3'b000, 2'b11, 1'b1, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                          3'b100), mk_verdict(1'b1, mfm_pkg::ERR_FILM, 4'h0));
        add_typed(mk_tick(3'b000, 2'b11, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                          3'b011), mk_verdict(1'b1, mfm_pkg::ERR_FILM, 4'h0));
        // short timeout: counts down, then holds at zero
        add_cfg(mfm_pkg::REG_FILM_TO, 32'd2);
        add_tick(mk_tick(3'b000, 2'b11, 1'b1, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b100));
        add_tick(mk_tick(3'b000, 2'b11, 1'b1, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b100));
        add_tick(mk_tick(3'b000, 2'b11, 1'b1, 1'b0, 1'b0, 3'b000, 3'b000, S0, S0, S0,
                         3'b110));
        add_cfg(REG_UNMAPPED, 32'hFFFF_FFFF);
        // longest blanking, restarted by the next phase's write
        add_cfg(mfm_pkg::REG_BLANKING, 32'd65535);
        add_typed(mk_tick(3'b111, 2'b00, 1'b1, 1'b0, 1'b1, 3'b111, 3'b111, SMAX, SMAX,
                          SMAX, 3'b111), mk_verdict(1'b0, mfm_pkg::ERR_NONE, 4'h0));
        add_typed(mk_tick(3'b101, 2'b10, 1'b0, 1'b0, 1'b1, 3'b111, 3'b111, SMAX, S0,
                          SMAX, 3'b011), mk_verdict(1'b0, mfm_pkg::ERR_NONE, 4'h0));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].act == ACT_CFG) begin
                wait_drained();
                program_reg(plan[i].idx, plan[i].value);
            end else begin
                push_tick(plan[i].tick, plan[i].fixed_want, plan[i].want);
            end
        end

        // random phases, each with its own register set and idle pattern
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 45; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 45; end
                default: begin src_idle_pct = 18; dst_stall_pct = 18; end
            endcase
            // upper pwdata bits carry junk; the block keeps only the register width
            for (k = 0; k < 3; k++) begin
                if (ph == 0)
                    val = 32'd0;
                else if (ph == 1)
                    val = 32'h00FF_FFFF;
                else if ($urandom_range(0, 1) == 1)
                    val = $urandom_range(0, 2000);
                else
                    val = $urandom() & 32'h00FF_FFFF;
                program_reg(mfm_pkg::t_reg_idx'(mfm_pkg::REG_M2_LIMIT + k),
                            val | ($urandom() & 32'hFF00_0000));
            end
            if (ph == 0)
                val = 32'd1;
            else if (ph == 1)
                val = 32'd65535;
            else
                val = $urandom_range(1, 40);
            program_reg(mfm_pkg::REG_FILM_TO, val | ($urandom() & 32'hFFFF_0000));
            val = (ph < 2) ? 32'd0 : $urandom_range(0, 8);
            program_reg(mfm_pkg::REG_BLANKING, val | ($urandom() & 32'hFFFF_0000));
            if (ph == 2)
                program_reg(mfm_pkg::t_reg_idx'($urandom_range(REG_UNMAPPED, 7)),
                            $urandom());

            for (n = 0; n < PHASE_TICKS; n++) begin
                // one hold-off mid-run until the pipe is empty
                if (ph == 3 && n == PHASE_TICKS / 2)
                    wait_drained();
                t = '0;
                // magnets and film sensor stay put for a while so the timer can run out
                if ($urandom_range(0, 99) < 8) begin
                    sim_mag  = 3'($urandom_range(0, 7));
                    sim_film = 1'($urandom_range(0, 1));
                end
                t.mag  = sim_mag;
                t.film = sim_film;
                // mostly a forward position sequence, some backward or multiple
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    t.pos = '0;
                end else if (r < 80) begin
                    t.pos    = fwd[seq_step];
                    seq_step = (seq_step + 1) % 3;
                end else if (r < 90) begin
                    t.pos = 3'b001 << $urandom_range(0, 2);
                end else begin
                    t.pos = 3'($urandom_range(0, 7));
                end
                t.guard   = ($urandom_range(0, 99) < 90) ? 2'b11 : 2'($urandom_range(0, 3));
                t.in_init = ($urandom_range(0, 99) < 10);
                t.init_ok = 1'($urandom_range(0, 1));
                t.en      = 3'($urandom_range(0, 7));
                t.home    = 3'($urandom_range(0, 7));
                // step counts cluster around the limits to hit both sides
                for (k = 0; k < 3; k++) begin
                    if ($urandom_range(0, 99) < 60)
                        t.steps[k] = mfm_pkg::STEP_W'(step_limit[k] +
                                                      $urandom_range(0, 4) - 2);
                    else
                        t.steps[k] = mfm_pkg::STEP_W'($urandom());
                end
                push_tick(t, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
